>>> hdl/tbpa_pkg.sv
// Shared types and constants of the tiered block pool allocator.
// Used by every module in hdl except tbpa_ram; depends on nothing.
package tbpa_pkg;

  localparam int NUM_POOLS   = 4;
  localparam int MAX_BLOCKS  = 32;
  localparam int POOL_W      = 2;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int SIZE_W      = 16;
  localparam int TRIES_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int RAM_DEPTH   = NUM_POOLS * MAX_BLOCKS;

  localparam logic [SIZE_W:0] SIZE_MARGIN = 17'd16;

  localparam int SMALL_BLOCKS_DEF  = 32;
  localparam int MEDIUM_BLOCKS_DEF = 16;
  localparam int LARGE_BLOCKS_DEF  = 8;
  localparam int HUGE_BLOCKS_DEF   = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_POOLS] =
    '{16'd64, 16'd256, 16'd1024, 16'd4096};

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUGE   = 3'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [POOL_W-1:0] block_pool;
    logic [IDX_W-1:0]  block_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POOL_W-1:0]  granted_pool;
    logic [IDX_W-1:0]   granted_index;
    logic [CNT_W-1:0]   pool_used;
    logic [CNT_W-1:0]   pool_peak;
    logic [TRIES_W-1:0] failed_tries;
  } out_item_t;

  typedef struct packed {
    logic                 kind;
    logic [NUM_POOLS-1:0] fit;
    logic [POOL_W-1:0]    block_pool;
    logic [IDX_W-1:0]     block_slot;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic not_empty;
    logic full;
    job_t job;
  } queue_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

>>> hdl/tbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/tbpa_front.sv
// Front end: block size registers, item intake and pool fit classification.
// Depends on tbpa_pkg.
module tbpa_front
  import tbpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  in_item_t             in_item,
  input  logic                 queue_full,
  output logic                 busy,
  output push_t                push,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0] size_r   [NUM_POOLS];
  logic [SIZE_W-1:0] size_nxt [NUM_POOLS];
  logic [SIZE_W:0]   need;
  logic [NUM_POOLS-1:0] fit;

  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      size_nxt[p] = size_r[p];
    end
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SMALL:  size_nxt[0] = cfg_data;
        CFG_MEDIUM: size_nxt[1] = cfg_data;
        CFG_LARGE:  size_nxt[2] = cfg_data;
        CFG_HUGE:   size_nxt[3] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        size_r[p] <= SIZE_RESET[p];
      end
    end else begin
      size_r <= size_nxt;
    end
  end

  assign need = {1'b0, in_item.request_size} + SIZE_MARGIN;

  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      fit[p] = (need <= {1'b0, size_r[p]});
    end
  end

  assign busy                 = queue_full;
  assign push.push            = start && !queue_full;
  assign push.job.kind        = in_item.kind;
  assign push.job.fit         = fit;
  assign push.job.block_pool  = in_item.block_pool;
  assign push.job.block_slot  = in_item.block_slot;

endmodule

>>> hdl/tbpa_queue.sv
// Short job queue between the front end and the pool engine.
// Depends on tbpa_pkg.
module tbpa_queue
  import tbpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  input  logic        pop,
  output queue_stat_t stat
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  job_t           slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_push, do_pop;

  assign do_push = push.push && (count_r != QCW'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push.job;
    end
  end

  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == QCW'(QUEUE_DEPTH));
  assign stat.job       = slot_r[rptr_r];

endmodule

>>> hdl/tbpa_back.sv
// Pool engine: free stacks, allocated bitmap, used and peak counts, results.
// Depends on tbpa_pkg and tbpa_ram.
module tbpa_back
  import tbpa_pkg::*;
#(
  parameter int SMALL_BLOCKS  = SMALL_BLOCKS_DEF,
  parameter int MEDIUM_BLOCKS = MEDIUM_BLOCKS_DEF,
  parameter int LARGE_BLOCKS  = LARGE_BLOCKS_DEF,
  parameter int HUGE_BLOCKS   = HUGE_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_stat_t qstat,
  output logic        pop,
  output logic        out_valid,
  output out_item_t   out_item
);

  localparam int RAW = $clog2(RAM_DEPTH);
  localparam logic [CNT_W-1:0] BLK [NUM_POOLS] = '{
    CNT_W'(SMALL_BLOCKS), CNT_W'(MEDIUM_BLOCKS),
    CNT_W'(LARGE_BLOCKS), CNT_W'(HUGE_BLOCKS)};

  back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      depth_r [NUM_POOLS];
  logic [CNT_W-1:0]      depth_nxt [NUM_POOLS];
  logic [CNT_W-1:0]      fill_r [NUM_POOLS];
  logic [CNT_W-1:0]      fill_nxt [NUM_POOLS];
  logic [CNT_W-1:0]      used_r [NUM_POOLS];
  logic [CNT_W-1:0]      used_nxt [NUM_POOLS];
  logic [CNT_W-1:0]      peak_r [NUM_POOLS];
  logic [CNT_W-1:0]      peak_nxt [NUM_POOLS];
  logic [MAX_BLOCKS-1:0] map_r [NUM_POOLS];
  logic [MAX_BLOCKS-1:0] map_nxt [NUM_POOLS];

  logic [POOL_W-1:0]  pool_r, pool_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               use_pos_r, use_pos_nxt;
  logic [TRIES_W-1:0] tries_r, tries_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic              ram_we, ram_re;
  logic [RAW-1:0]    ram_waddr, ram_raddr;
  logic [IDX_W-1:0]  ram_wdata, ram_rdata;

  job_t              job;
  logic              found;
  logic [POOL_W-1:0] sel;
  logic [TRIES_W-1:0] tries;
  logic [CNT_W-1:0]  top;
  logic [IDX_W-1:0]  idx;
  logic [POOL_W-1:0] fp;
  logic [IDX_W-1:0]  fi;
  logic              free_ok;
  logic [CNT_W-1:0]  used_inc;

  tbpa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(RAM_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign job = qstat.job;
  assign fp  = job.block_pool;
  assign fi  = job.block_slot;

  // first fitting pool with a free block; earlier fitting pools are exhausted
  always_comb begin
    found = 1'b0;
    sel   = '0;
    tries = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (!found && job.fit[p]) begin
        if (depth_r[p] == '0 || depth_r[p] > CNT_W'(MAX_BLOCKS)) begin
          tries = tries + 1'b1;
        end else begin
          found = 1'b1;
          sel   = POOL_W'(p);
        end
      end
    end
  end

  assign top     = depth_r[sel] - 1'b1;
  assign free_ok = ({1'b0, fi} < BLK[fp]) && map_r[fp][fi]
                   && (depth_r[fp] < CNT_W'(MAX_BLOCKS));
  assign idx      = use_pos_r ? pos_r : ram_rdata;
  assign used_inc = used_r[pool_r] + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    fill_nxt      = fill_r;
    used_nxt      = used_r;
    peak_nxt      = peak_r;
    map_nxt       = map_r;
    pool_nxt      = pool_r;
    pos_nxt       = pos_r;
    use_pos_nxt   = use_pos_r;
    tries_nxt     = tries_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {fp, depth_r[fp][IDX_W-1:0]};
    ram_wdata     = fi;
    ram_re        = 1'b0;
    ram_raddr     = {sel, top[IDX_W-1:0]};

    unique case (state_r)
      BK_IDLE: begin
        if (qstat.not_empty) begin
          pop = 1'b1;
          if (job.kind == KIND_ALLOC) begin
            if (found) begin
              ram_re         = 1'b1;
              depth_nxt[sel] = top;
              // positions below the fill mark still hold their reset index
              use_pos_nxt    = (top < fill_r[sel]);
              if (top < fill_r[sel]) begin
                fill_nxt[sel] = top;
              end
              pool_nxt  = sel;
              pos_nxt   = top[IDX_W-1:0];
              tries_nxt = tries;
              state_nxt = BK_READ;
            end else begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '0;
              out_item_nxt.status       = (job.fit != '0) ? ST_EXHAUSTED : ST_TOO_LARGE;
              out_item_nxt.failed_tries = tries;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
            if (free_ok) begin
              ram_we            = 1'b1;
              map_nxt[fp][fi]   = 1'b0;
              depth_nxt[fp]     = depth_r[fp] + 1'b1;
              used_nxt[fp]      = (used_r[fp] != '0) ? used_r[fp] - 1'b1 : used_r[fp];
              out_item_nxt.status        = ST_OK;
              out_item_nxt.granted_pool  = fp;
              out_item_nxt.granted_index = fi;
              out_item_nxt.pool_used     = used_nxt[fp];
              out_item_nxt.pool_peak     = peak_r[fp];
            end else begin
              out_item_nxt.status = ST_BAD_FREE;
            end
          end
        end
      end
      BK_READ: begin
        map_nxt[pool_r][idx] = 1'b1;
        used_nxt[pool_r]     = used_inc;
        if (used_inc > peak_r[pool_r]) begin
          peak_nxt[pool_r] = used_inc;
        end
        out_valid_nxt              = 1'b1;
        out_item_nxt.status        = ST_OK;
        out_item_nxt.granted_pool  = pool_r;
        out_item_nxt.granted_index = idx;
        out_item_nxt.pool_used     = used_inc;
        out_item_nxt.pool_peak     = peak_nxt[pool_r];
        out_item_nxt.failed_tries  = tries_r;
        state_nxt                  = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        depth_r[p] <= BLK[p];
        fill_r[p]  <= BLK[p];
        used_r[p]  <= '0;
        peak_r[p]  <= '0;
        map_r[p]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      depth_r     <= depth_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      map_r       <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pool_r     <= pool_nxt;
    pos_r      <= pos_nxt;
    use_pos_r  <= use_pos_nxt;
    tries_r    <= tries_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> hdl/tiered_block_pool_allocator_top.sv
// Top level of the tiered block pool allocator: front end, job queue, pool engine.
// Depends on tbpa_pkg, tbpa_front, tbpa_queue, tbpa_back (and tbpa_ram below it).
//
//   channel | ports                           | handshake
//   input   | start, busy, in_item            | taken when start && !busy
//   result  | out_valid, out_item             | one-cycle strobe, no backpressure
//   config  | cfg_we, cfg_index, cfg_data     | written when cfg_we, no wait
//
// A free's result is registered when the engine pops it from the job queue; an
// allocate first passes BK_READ, the registered read of the free stack RAM. The
// engine takes one free per cycle and no job while in BK_READ. busy rises when the
// two-entry job queue is full. No clearing pass after reset: a per-pool fill
// mark supplies the initial stack contents. Results are never held off.
module tiered_block_pool_allocator_top
  import tbpa_pkg::*;
#(
  parameter int SMALL_BLOCKS  = SMALL_BLOCKS_DEF,
  parameter int MEDIUM_BLOCKS = MEDIUM_BLOCKS_DEF,
  parameter int LARGE_BLOCKS  = LARGE_BLOCKS_DEF,
  parameter int HUGE_BLOCKS   = HUGE_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  push_t       push;
  queue_stat_t qstat;
  logic        pop;

  tbpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .queue_full(qstat.full),
    .busy      (busy),
    .push      (push),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tbpa_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .stat (qstat)
  );

  tbpa_back #(
    .SMALL_BLOCKS (SMALL_BLOCKS),
    .MEDIUM_BLOCKS(MEDIUM_BLOCKS),
    .LARGE_BLOCKS (LARGE_BLOCKS),
    .HUGE_BLOCKS  (HUGE_BLOCKS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

>>> verif/tiered_block_pool_allocator_top_test.sv
// Self-checking test of tiered_block_pool_allocator_top: directed allocate/free words, then
// random phases under several block-size settings, with random sender gaps in some phases.
// Depends on tbpa_pkg and the allocator RTL under hdl.
module tiered_block_pool_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tbpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] SIZE_REGS [NUM_POOLS] =
    '{CFG_SMALL, CFG_MEDIUM, CFG_LARGE, CFG_HUGE};
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;
  localparam int PHASE_WORDS = 225;

  class pool_ledger;
    int unsigned       blocks_in [NUM_POOLS];
    logic [SIZE_W-1:0] block_bytes [NUM_POOLS];
    logic [IDX_W-1:0]  spare_stack [NUM_POOLS][MAX_BLOCKS];
    int unsigned       free_top [NUM_POOLS];
    bit                in_use [NUM_POOLS][MAX_BLOCKS];
    int unsigned       used [NUM_POOLS];
    int unsigned       peak [NUM_POOLS];
    out_item_t         awaited_grants [$];
    int unsigned       mismatches;

    function new();
      blocks_in = '{SMALL_BLOCKS_DEF, MEDIUM_BLOCKS_DEF, LARGE_BLOCKS_DEF, HUGE_BLOCKS_DEF};
      mismatches = 0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        block_bytes[p] = SIZE_RESET[p];
        free_top[p] = blocks_in[p];
        used[p] = 0;
        peak[p] = 0;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
          spare_stack[p][k] = IDX_W'(k);
          in_use[p][k] = 1'b0;
        end
      end
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      if (idx < NUM_POOLS) block_bytes[idx[POOL_W-1:0]] = data;
    endfunction

    function void take_request(in_item_t w);
      out_item_t         r;
      logic [SIZE_W:0]   need;
      bit                fits;
      bit                placed;
      int unsigned       p;
      r = '0;
      fits = 1'b0;
      placed = 1'b0;
      if (w.kind == KIND_ALLOC) begin
        need = {1'b0, w.request_size} + SIZE_MARGIN;
        for (int q = 0; q < NUM_POOLS; q++) begin
          if (!placed && need <= {1'b0, block_bytes[q]}) begin
            fits = 1'b1;
            if (free_top[q] == 0) begin
              r.failed_tries = r.failed_tries + 1'b1;
            end else begin
              free_top[q]--;
              r.granted_index = spare_stack[q][free_top[q]];
              in_use[q][r.granted_index] = 1'b1;
              used[q]++;
              if (used[q] > peak[q]) peak[q] = used[q];
              r.status = ST_OK;
              r.granted_pool = POOL_W'(q);
              r.pool_used = CNT_W'(used[q]);
              r.pool_peak = CNT_W'(peak[q]);
              placed = 1'b1;
            end
          end
        end
        if (!placed) r.status = fits ? ST_EXHAUSTED : ST_TOO_LARGE;
      end else begin
        p = w.block_pool;
        if (w.block_slot >= blocks_in[p] || !in_use[p][w.block_slot]) begin
          r.status = ST_BAD_FREE;
        end else begin
          in_use[p][w.block_slot] = 1'b0;
          spare_stack[p][free_top[p]] = w.block_slot;
          free_top[p]++;
          used[p]--;
          r.status = ST_OK;
          r.granted_pool = w.block_pool;
          r.granted_index = w.block_slot;
          r.pool_used = CNT_W'(used[p]);
          r.pool_peak = CNT_W'(peak[p]);
        end
      end
      awaited_grants.push_back(r);
    endfunction

    function bit pick_live(output logic [POOL_W-1:0] p, output logic [IDX_W-1:0] i);
      int unsigned cands [$];
      int unsigned sel;
      p = '0;
      i = '0;
      for (int q = 0; q < NUM_POOLS; q++)
        for (int k = 0; k < MAX_BLOCKS; k++)
          if (in_use[q][k]) cands.push_back(q * MAX_BLOCKS + k);
      if (cands.size() == 0) return 1'b0;
      sel = cands[$urandom_range(cands.size() - 1)];
      p = POOL_W'(sel / MAX_BLOCKS);
      i = IDX_W'(sel % MAX_BLOCKS);
      return 1'b1;
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (awaited_grants.size() == 0) begin
        $error("result word %h arrived with nothing outstanding", got);
        mismatches++;
        return;
      end
      want = awaited_grants.pop_front();
      compare("status", 8'(want.status), 8'(got.status));
      compare("granted_pool", 8'(want.granted_pool), 8'(got.granted_pool));
      compare("granted_index", 8'(want.granted_index), 8'(got.granted_index));
      compare("pool_used", 8'(want.pool_used), 8'(got.pool_used));
      compare("pool_peak", 8'(want.pool_peak), 8'(got.pool_peak));
      compare("failed_tries", 8'(want.failed_tries), 8'(got.failed_tries));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;

  int unsigned idle_pct = 0;
  int unsigned alloc_pct = 50;
  pool_ledger  ledger = new();

  tiered_block_pool_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) ledger.match_result(out_item);
  end

  task automatic offer_word(in_item_t w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy);
    ledger.take_request(w);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (ledger.awaited_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sizes(logic [SIZE_W-1:0] s0, s1, s2, s3);
    logic [SIZE_W-1:0] sizes [NUM_POOLS];
    logic [CFG_IDX_W-1:0] spare;
    logic [SIZE_W-1:0] junk;
    sizes = '{s0, s1, s2, s3};
    for (int k = 0; k < NUM_POOLS; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= SIZE_REGS[k];
      cfg_data <= sizes[k];
      @(posedge clk);
      ledger.set_size(SIZE_REGS[k], sizes[k]);
    end
    // unmapped index: must leave every size alone
    spare = CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
    junk = SIZE_W'($urandom);
    cfg_index <= spare;
    cfg_data <= junk;
    @(posedge clk);
    ledger.set_size(spare, junk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t word_of(logic kind, logic [SIZE_W-1:0] bytes,
                                       logic [POOL_W-1:0] p, logic [IDX_W-1:0] i);
    in_item_t w;
    w.kind = kind;
    w.request_size = bytes;
    w.block_pool = p;
    w.block_slot = i;
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t          w;
    logic [POOL_W-1:0] p;
    logic [IDX_W-1:0]  i;
    int                near;
    int unsigned       roll;
    w = in_item_t'(($bits(in_item_t))'($urandom));
    roll = $urandom_range(99);
    if (roll < alloc_pct) begin
      w.kind = KIND_ALLOC;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          near = int'(ledger.block_bytes[$urandom_range(NUM_POOLS - 1)]) - int'(SIZE_MARGIN)
                 + int'($urandom_range(2)) - 1;
          w.request_size = (near < 0) ? '0 : (near > 65535) ? '1 : SIZE_W'(near);
        end
        6, 7: w.request_size = SIZE_W'($urandom_range(200));
        8: ;
        default: w.request_size = $urandom_range(1) ? '1 : '0;
      endcase
    end else begin
      w.kind = KIND_FREE;
      if (roll < 88 && ledger.pick_live(p, i)) begin
        w.block_pool = p;
        w.block_slot = i;
      end
    end
    return w;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_sizes(16'd64, 16'd256, 16'd1024, 16'd4096);
    offer_word(word_of(KIND_ALLOC, 16'd0, 2'd0, 5'd0));
    offer_word(word_of(KIND_ALLOC, 16'd48, 2'd0, 5'd0));
    offer_word(word_of(KIND_ALLOC, 16'd49, 2'd0, 5'd0));
    offer_word(word_of(KIND_ALLOC, 16'd4080, 2'd0, 5'd0));
    offer_word(word_of(KIND_ALLOC, 16'd4081, 2'd0, 5'd0));
    offer_word(word_of(KIND_ALLOC, 16'hFFFF, 2'd0, 5'd0));
    repeat (3) offer_word(word_of(KIND_ALLOC, 16'd4080, 2'd0, 5'd0));
    offer_word(word_of(KIND_ALLOC, 16'd4080, 2'd0, 5'd0));
    offer_word(word_of(KIND_FREE, 16'd0, 2'd3, 5'd0));
    offer_word(word_of(KIND_FREE, 16'd0, 2'd3, 5'd0));
    offer_word(word_of(KIND_FREE, 16'd0, 2'd3, 5'd4));
    offer_word(word_of(KIND_FREE, 16'd0, 2'd2, 5'd31));
    offer_word(word_of(KIND_FREE, 16'd0, 2'd0, 5'd0));
    offer_word(word_of(KIND_FREE, 16'd0, 2'd0, 5'd31));
    offer_word(word_of(KIND_ALLOC, 16'd0, 2'd0, 5'd0));
    offer_word(word_of(KIND_ALLOC, 16'd1000, 2'd3, 5'd31));
    offer_word(word_of(KIND_FREE, 16'hFFFF, 2'd1, 5'd15));
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          idle_pct = 52;
          alloc_pct = 75;
        end
        1: begin
          write_sizes(16'd16, 16'd17, 16'd0, 16'd1);
          idle_pct = 20;
          alloc_pct = 60;
        end
        2: begin
          write_sizes(16'd4096, 16'd1024, 16'd256, 16'd64);
          idle_pct = 0;
          alloc_pct = 55;
        end
        3: begin
          write_sizes(SIZE_W'($urandom_range(16, 3000)), SIZE_W'($urandom_range(16, 3000)),
                      SIZE_W'($urandom_range(16, 3000)), SIZE_W'($urandom_range(1, 65535)));
          idle_pct = 52;
          alloc_pct = 50;
        end
        4: begin
          write_sizes(16'd100, 16'd200, 16'd300, 16'hFFFF);
          idle_pct = 20;
          alloc_pct = 65;
        end
        default: begin
          write_sizes(SIZE_W'($urandom_range(1, 65535)), SIZE_W'($urandom_range(1, 65535)),
                      SIZE_W'($urandom_range(1, 65535)), SIZE_W'($urandom_range(1, 65535)));
          idle_pct = 0;
          alloc_pct = 45;
        end
      endcase
      repeat (PHASE_WORDS) offer_word(random_word());
      settle();
    end

    if (ledger.mismatches == 0) begin
      $display("** tiered_block_pool_allocator_top: PASSED **");
    end else begin
      $display("** tiered_block_pool_allocator_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** tiered_block_pool_allocator_top: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
hdl/tbpa_pkg.sv
hdl/tbpa_ram.sv
hdl/tbpa_front.sv
hdl/tbpa_queue.sv
hdl/tbpa_back.sv
hdl/tiered_block_pool_allocator_top.sv
verif/tiered_block_pool_allocator_top_test.sv
